[hdl/assert_macros.svh]
// Assertion macros shared by the permutation order finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

[hdl/pof_pkg.sv]
// Shared constants, types and the factorial limit table of the order finder.
package pof_pkg;

  localparam int MAX_SIZE    = 16;
  localparam int VAL_W       = 5;
  localparam int IDX_W       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int CNT_W       = $clog2(MAX_SIZE + 1);
  localparam int CMP_W       = ((VAL_W > CNT_W) ? VAL_W : CNT_W) + 1;
  localparam int ORDER_W     = 16;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = ((VAL_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ORDER_W + STAT_W + 7) / 8) * 8;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_INPUT = 2'd1,
    STAT_LIMIT     = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_PASS,
    S_FINISH
  } state_t;

  // view of the permutation as it stands after the item being accepted
  typedef struct packed {
    logic [CNT_W-1:0] size;
    logic             bad;
    logic             ident;
  } load_sum_t;

  typedef struct packed {
    logic done;
    logic ident;
  } pass_sum_t;

  // n factorial, saturated at the top of the order range
  function automatic logic [ORDER_W-1:0] fact_cap(input logic [CNT_W-1:0] n);
    logic [ORDER_W-1:0] v;
    case (int'(n))
      0, 1:    v = ORDER_W'(1);
      2:       v = ORDER_W'(2);
      3:       v = ORDER_W'(6);
      4:       v = ORDER_W'(24);
      5:       v = ORDER_W'(120);
      6:       v = ORDER_W'(720);
      7:       v = ORDER_W'(5040);
      8:       v = ORDER_W'(40320);
      default: v = '1;
    endcase
    return v;
  endfunction

endpackage

[hdl/permutation_order_finder.sv]
// Permutation order finder: elements load at one per cycle into a RAM, and a
// copy into a power buffer RAM. The item with tlast ends the permutation; if
// an element was bad or the permutation is the identity, the result goes to
// the output register via the finish state. Otherwise the block runs
// composition passes over the power buffer, each of n gather steps for a size
// n through the two registered RAM reads plus pipeline drain, until the buffer
// is the identity. A map that is not a bijection runs until the count passes
// min(n!, 65535) and reports the limit status. Input is stalled from the last
// element until the result is in the output register.
module permutation_order_finder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [pof_pkg::IN_TDATA_W-1:0]  in_tdata,   // [4:0] element_value
  input  logic                           in_tlast,   // is_last
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pof_pkg::OUT_TDATA_W-1:0] out_tdata   // [15:0] order, [17:16] status
);
  import pof_pkg::*;

  `include "assert_macros.svh"

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   size_r, size_nxt;
  logic [ORDER_W-1:0] order_r, order_nxt;
  logic [ORDER_W-1:0] limit_r, limit_nxt;
  stat_t              stat_r, stat_nxt;

  logic               out_tvalid_r;
  logic [ORDER_W-1:0] out_order_r;
  stat_t              out_status_r;
  logic               out_load;

  logic               in_acc;
  logic [VAL_W-1:0]   in_val;
  logic               cp_start;

  logic               ld_we;
  logic [IDX_W-1:0]   ld_addr;
  load_sum_t          ld_sum;

  logic [VAL_W-1:0]   buf_rdata, perm_rdata;
  logic [IDX_W-1:0]   buf_raddr, perm_raddr;
  logic               cp_we;
  logic [IDX_W-1:0]   cp_waddr;
  logic [VAL_W-1:0]   cp_wdata;
  pass_sum_t          pass;

  logic               buf_we;
  logic [IDX_W-1:0]   buf_waddr;
  logic [VAL_W-1:0]   buf_wdata;

  assign in_acc = in_tvalid & in_tready;
  assign in_val = in_tdata[VAL_W-1:0];

  pof_load u_load (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_acc),
    .value   (in_val),
    .last    (in_tlast),
    .wr_en   (ld_we),
    .wr_addr (ld_addr),
    .sum     (ld_sum)
  );

  pof_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SIZE)) u_perm_ram (
    .clk   (clk),
    .we    (ld_we),
    .waddr (ld_addr),
    .wdata (in_val),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  // loading and composing never overlap, so the write port is shared
  always_comb begin
    buf_we    = ld_we | cp_we;
    buf_waddr = ld_we ? ld_addr : cp_waddr;
    buf_wdata = ld_we ? in_val : cp_wdata;
  end

  pof_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SIZE)) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  pof_compose u_compose (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cp_start),
    .size       (size_r),
    .buf_rdata  (buf_rdata),
    .perm_rdata (perm_rdata),
    .buf_raddr  (buf_raddr),
    .perm_raddr (perm_raddr),
    .buf_we     (cp_we),
    .buf_waddr  (cp_waddr),
    .buf_wdata  (cp_wdata),
    .pass       (pass)
  );

  always_comb begin
    state_nxt = state_r;
    size_nxt  = size_r;
    order_nxt = order_r;
    limit_nxt = limit_r;
    stat_nxt  = stat_r;
    cp_start  = 1'b0;
    in_tready = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid && in_tlast) begin
          size_nxt  = ld_sum.size;
          limit_nxt = fact_cap(ld_sum.size);
          order_nxt = ORDER_W'(1);
          stat_nxt  = STAT_OK;
          if (ld_sum.bad) begin
            stat_nxt  = STAT_BAD_INPUT;
            order_nxt = '0;
            state_nxt = S_FINISH;
          end else if (ld_sum.ident) begin
            state_nxt = S_FINISH;
          end else begin
            cp_start  = 1'b1;
            state_nxt = S_PASS;
          end
        end
      end
      S_PASS: begin
        if (pass.done) begin
          // order+1 > limit, tested before the increment
          if (order_r >= limit_r) begin
            stat_nxt  = STAT_LIMIT;
            order_nxt = '0;
            state_nxt = S_FINISH;
          end else begin
            order_nxt = order_r + ORDER_W'(1);
            if (pass.ident) begin
              state_nxt = S_FINISH;
            end else begin
              cp_start = 1'b1;
            end
          end
        end
      end
      S_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    size_r  <= size_nxt;
    order_r <= order_nxt;
    limit_r <= limit_nxt;
    stat_r  <= stat_nxt;
    if (out_load) begin
      out_order_r  <= order_r;
      out_status_r <= stat_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({out_status_r, out_order_r});

  `ASSERT_CLK(a_ok_order, out_tvalid_r && (out_status_r == STAT_OK) |-> out_order_r != '0, "ok result with zero order")
  `ASSERT_CLK(a_order_limit, (state_r == S_PASS) |-> order_r <= limit_r, "order ran past limit")
  `ASSERT_CLK(a_out_from_finish, $rose(out_tvalid_r) |-> $past(state_r == S_FINISH), "result not from finish")

endmodule

[hdl/pof_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module pof_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/pof_load.sv]
// Input side: element count, bad-input tracking and the running identity check.
module pof_load (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [pof_pkg::VAL_W-1:0] value,
  input  logic                      last,
  output logic                      wr_en,
  output logic [pof_pkg::IDX_W-1:0] wr_addr,
  output pof_pkg::load_sum_t        sum
);
  import pof_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic             bad_r;
  logic [VAL_W-1:0] max_r;
  logic             ident_r;

  logic             full;
  logic [CNT_W-1:0] n_after;
  logic             bad_after;
  logic [VAL_W-1:0] max_after;
  logic             ident_after;

  always_comb begin
    full        = (count_r == CNT_W'(MAX_SIZE));
    n_after     = full ? count_r : count_r + CNT_W'(1);
    bad_after   = bad_r | full | (value == '0) | (CMP_W'(value) > CMP_W'(MAX_SIZE));
    max_after   = (!full && (value > max_r)) ? value : max_r;
    ident_after = ident_r & !full &
                  (CMP_W'(value) == (CMP_W'(count_r) + CMP_W'(1)));
    // an image above the final size is only known once the size is
    sum.size    = n_after;
    sum.bad     = bad_after | (CMP_W'(max_after) > CMP_W'(n_after));
    sum.ident   = ident_after;
    wr_en       = accept & !full;
    wr_addr     = IDX_W'(count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bad_r   <= 1'b0;
      max_r   <= '0;
      ident_r <= 1'b1;
    end else if (accept) begin
      if (last) begin
        count_r <= '0;
        bad_r   <= 1'b0;
        max_r   <= '0;
        ident_r <= 1'b1;
      end else begin
        count_r <= n_after;
        bad_r   <= bad_after;
        max_r   <= max_after;
        ident_r <= ident_after;
      end
    end
  end

endmodule

[hdl/pof_compose.sv]
// One composition pass: buf[i] <= perm[buf[i]-1] over all positions, in place.
module pof_compose (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pof_pkg::CNT_W-1:0] size,
  input  logic [pof_pkg::VAL_W-1:0] buf_rdata,
  input  logic [pof_pkg::VAL_W-1:0] perm_rdata,
  output logic [pof_pkg::IDX_W-1:0] buf_raddr,
  output logic [pof_pkg::IDX_W-1:0] perm_raddr,
  output logic                      buf_we,
  output logic [pof_pkg::IDX_W-1:0] buf_waddr,
  output logic [pof_pkg::VAL_W-1:0] buf_wdata,
  output pof_pkg::pass_sum_t        pass
);
  import pof_pkg::*;

  `include "assert_macros.svh"

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic             s1_v_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s2_v_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic             ident_r;
  logic             done_r;

  logic             issue_last;
  logic             s2_last;
  logic             s2_match;

  // powers of one map commute, so P^(k+1)(i) = P(P^k(i)) lets the buffer update in place
  always_comb begin
    issue_last = (cnt_r == size - CNT_W'(1));
    s2_last    = (CNT_W'(s2_idx_r) == size - CNT_W'(1));
    s2_match   = (CMP_W'(perm_rdata) == (CMP_W'(s2_idx_r) + CMP_W'(1)));
    buf_raddr  = IDX_W'(cnt_r);
    perm_raddr = IDX_W'(buf_rdata - VAL_W'(1));
    buf_we     = s2_v_r;
    buf_waddr  = s2_idx_r;
    buf_wdata  = perm_rdata;
    pass.done  = done_r;
    pass.ident = ident_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      ident_r <= 1'b1;
      done_r  <= 1'b0;
    end else begin
      s1_v_r <= busy_r;
      s2_v_r <= s1_v_r;
      done_r <= s2_v_r & s2_last;
      if (start) begin
        busy_r  <= 1'b1;
        cnt_r   <= '0;
        ident_r <= 1'b1;
      end else begin
        if (busy_r) begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (issue_last) begin
            busy_r <= 1'b0;
          end
        end
        if (s2_v_r) begin
          ident_r <= ident_r & s2_match;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= IDX_W'(cnt_r);
    s2_idx_r <= s1_idx_r;
  end

  `ASSERT_CLK(a_start_idle, start |-> !busy_r && !s1_v_r && !s2_v_r, "pass started while busy")
  `ASSERT_NEVER(a_rw_same, busy_r && s2_v_r && (s2_idx_r == IDX_W'(cnt_r)), "read and write hit one entry")
  `ASSERT_CLK(a_done_drained, done_r |-> !busy_r && !s1_v_r, "pass done before drain")

endmodule
